// ===== sv/assert_macros.svh =====
// assertion macros used by the governor core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define LTLG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication from one cycle to the next
`define LTLG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ltlg_pkg.sv =====
// types and constants of the load threshold level governor
package ltlg_pkg;

  // number of operating points
  localparam int unsigned LEVELS = 16;

  localparam int unsigned KindW   = 2;
  localparam int unsigned LoadW   = 14;
  localparam int unsigned ElapsW  = 24;
  localparam int unsigned LevelW  = 4;
  localparam int unsigned ThrW    = 7;
  localparam int unsigned HoldW   = 16;
  localparam int unsigned MsW     = 15;
  localparam int unsigned CountW  = 18;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  // percent to hundredths of a percent
  localparam logic [LoadW-1:0] PctScale = 14'd100;

  // elapsed_us / 1000 as multiply by ceil(2^34 / 1000) and shift by 34
  localparam int unsigned      MsShift = 34;
  localparam logic [24:0]      MsRecip = 25'd17179870;
  localparam int unsigned      ProdW   = ElapsW + 25;

  // highest level index, widened so a level plus one compares cleanly
  localparam logic [6:0]       LevelTop = 7'(LEVELS - 1);

  typedef enum logic [KindW-1:0] {
    KindEval  = 2'd0,
    KindStart = 2'd1,
    KindStop  = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegUpThr   = 3'd0,
    RegDnThr   = 3'd1,
    RegUpHold  = 3'd2,
    RegDnHold  = 3'd3,
    RegMinLvl  = 3'd4,
    RegMaxLvl  = 3'd5,
    RegStartLvl = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [ThrW-1:0]   up_thr;
    logic [ThrW-1:0]   dn_thr;
    logic [HoldW-1:0]  up_hold;
    logic [HoldW-1:0]  dn_hold;
    logic [LevelW-1:0] min_lvl;
    logic [LevelW-1:0] max_lvl;
    logic [LevelW-1:0] start_lvl;
  } cfg_t;

  // one accepted item after the input register
  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [LevelW-1:0] cur;
    logic [MsW-1:0]    ms;
    logic              high;
    logic              low;
  } item_t;

endpackage

// ===== sv/ltlg_cfg.sv =====
// configuration register file of the governor
module ltlg_cfg (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_index_i,
  input  logic [15:0]             cfg_data_i,
  output ltlg_pkg::cfg_t          cfg_o
);
  import ltlg_pkg::*;

  cfg_t cfg_q, cfg_d;

  // decode the write index, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        RegUpThr:    cfg_d.up_thr    = cfg_data_i[ThrW-1:0];
        RegDnThr:    cfg_d.dn_thr    = cfg_data_i[ThrW-1:0];
        RegUpHold:   cfg_d.up_hold   = cfg_data_i[HoldW-1:0];
        RegDnHold:   cfg_d.dn_hold   = cfg_data_i[HoldW-1:0];
        RegMinLvl:   cfg_d.min_lvl   = cfg_data_i[LevelW-1:0];
        RegMaxLvl:   cfg_d.max_lvl   = cfg_data_i[LevelW-1:0];
        RegStartLvl: cfg_d.start_lvl = cfg_data_i[LevelW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.up_thr    <= 7'd80;
      cfg_q.dn_thr    <= 7'd40;
      cfg_q.up_hold   <= 16'd100;
      cfg_q.dn_hold   <= 16'd100;
      cfg_q.min_lvl   <= 4'd0;
      cfg_q.max_lvl   <= 4'd15;
      cfg_q.start_lvl <= 4'd15;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/ltlg_front.sv =====
// input stage: ms conversion, threshold compares and the input register
module ltlg_front (
  input  logic                    clk_i,
  input  logic                    load_en_i,
  input  logic [1:0]              kind_i,
  input  logic [13:0]             load_i,
  input  logic [23:0]             elapsed_us_i,
  input  logic [3:0]              current_level_i,
  input  ltlg_pkg::cfg_t          cfg_i,
  output ltlg_pkg::item_t         item_o
);
  import ltlg_pkg::*;

  logic [ProdW-1:0] prod;
  logic [LoadW-1:0] up_lim;
  logic [LoadW-1:0] dn_lim;
  item_t            item_d, item_q;

  // reciprocal multiply gives the exact quotient over the full 24-bit range
  assign prod = ProdW'(elapsed_us_i) * ProdW'(MsRecip);

  // thresholds in hundredths of a percent, at most 12700
  assign up_lim = LoadW'(cfg_i.up_thr) * PctScale;
  assign dn_lim = LoadW'(cfg_i.dn_thr) * PctScale;

  always_comb begin
    item_d.kind = kind_i;
    item_d.cur  = current_level_i;
    item_d.ms   = prod[MsShift +: MsW];
    item_d.high = load_i > up_lim;
    item_d.low  = load_i < dn_lim;
  end

  // payload register, loaded on an input transfer
  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

// ===== sv/ltlg_core.sv =====
// hold counters, level decision, handshake and result register
module ltlg_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  output logic                    load_en_o,
  input  ltlg_pkg::item_t         item_i,
  input  ltlg_pkg::cfg_t          cfg_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    request_valid_o,
  output logic [3:0]              requested_level_o
);
  import ltlg_pkg::*;

  `include "assert_macros.svh"

  logic                     item_vld_q, item_vld_d;
  logic                     out_vld_q, out_vld_d;
  logic                     res_free, advance, in_xfer;
  logic signed [CountW-1:0] up_q, up_d, dn_q, dn_d;
  logic signed [CountW-1:0] ms_s, up_rel, dn_rel, up_sub, dn_base, dn_sub;
  logic [LevelW:0]          next_lvl;
  logic                     req_vld_q, req_vld_d;
  logic [LevelW-1:0]        req_lvl_q, req_lvl_d;

  // handshake: the item register drains whenever the result register frees up
  assign res_free   = !out_vld_q || !out_stall_i;
  assign advance    = item_vld_q && res_free;
  assign in_stall_o = item_vld_q && !res_free;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign load_en_o  = in_xfer;

  always_comb begin
    item_vld_d = item_vld_q;
    if (in_xfer) begin
      item_vld_d = 1'b1;
    end else if (advance) begin
      item_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  // counter arithmetic, the down side starts from its reload when load is also high
  assign ms_s     = $signed({3'b000, item_i.ms});
  assign up_rel   = $signed({2'b00, cfg_i.up_hold});
  assign dn_rel   = $signed({2'b00, cfg_i.dn_hold});
  assign up_sub   = up_q - ms_s;
  assign dn_base  = item_i.high ? dn_rel : dn_q;
  assign dn_sub   = dn_base - ms_s;
  assign next_lvl = {1'b0, item_i.cur} + 5'd1;

  // level decision
  always_comb begin
    up_d      = up_q;
    dn_d      = dn_q;
    req_vld_d = 1'b0;
    req_lvl_d = '0;
    case (item_i.kind)
      KindEval: begin
        if (item_i.high) begin
          up_d = up_sub;
          dn_d = dn_rel;
          if (up_sub <= 0) begin
            if (item_i.cur < cfg_i.max_lvl) begin
              req_vld_d = 1'b1;
              req_lvl_d = ({2'b00, next_lvl} > LevelTop) ? item_i.cur
                                                         : next_lvl[LevelW-1:0];
            end
            up_d = up_rel;
          end
        end
        if (item_i.low) begin
          up_d = up_rel;
          dn_d = dn_sub;
          if (dn_sub <= 0) begin
            if (item_i.cur > cfg_i.min_lvl) begin
              req_vld_d = 1'b1;
              req_lvl_d = item_i.cur - 4'd1;
            end
            dn_d = dn_rel;
          end
        end
        if (!item_i.high && !item_i.low) begin
          up_d = up_rel;
          dn_d = dn_rel;
        end
      end
      KindStart: begin
        up_d      = up_rel;
        dn_d      = dn_rel;
        req_vld_d = 1'b1;
        req_lvl_d = ({3'b000, cfg_i.start_lvl} > LevelTop) ? LevelTop[LevelW-1:0]
                                                           : cfg_i.start_lvl;
      end
      KindStop: begin
        up_d      = up_rel;
        dn_d      = dn_rel;
        req_vld_d = 1'b1;
        req_lvl_d = cfg_i.min_lvl;
      end
      default: begin
        up_d = up_q;
        dn_d = dn_q;
      end
    endcase
  end

  // control and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      up_q       <= '0;
      dn_q       <= '0;
    end else begin
      item_vld_q <= item_vld_d;
      out_vld_q  <= out_vld_d;
      if (advance) begin
        up_q <= up_d;
        dn_q <= dn_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      req_vld_q <= req_vld_d;
      req_lvl_q <= req_lvl_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign request_valid_o   = req_vld_q;
  assign requested_level_o = req_lvl_q;

  // stored counters hold zero from reset, a reload value or a positive remainder
  `LTLG_ASSERT(a_counters_nonneg, (up_q >= 0) && (dn_q >= 0), "hold counter went negative")
  // counters only move when an item is handed to the result register
  `LTLG_ASSERT_NEXT(a_counters_hold, !advance, $stable(up_q) && $stable(dn_q), "counter moved without item")
  // the input side stalls only behind a full, stalled result register
  `LTLG_ASSERT(a_stall_cause, !in_stall_o || (out_vld_q && out_stall_i && item_vld_q), "spurious input stall")
  // no request means a zero level on the result
  `LTLG_ASSERT(a_idle_level, !(out_vld_q && !req_vld_q) || (req_lvl_q == '0), "level set without request")

endmodule

// ===== sv/load_threshold_level_governor.sv =====
// Load threshold level governor: steps the operating point index up or down after a load
// has stayed above or below its threshold for a hold time in milliseconds, and requests the
// start or minimum level on start and stop items. One item is accepted per clock cycle
// while input stall is low; each item gives exactly one result, passing through the input
// register (where elapsed microseconds become milliseconds by a reciprocal multiply and the
// load is compared with both thresholds) and then the result register (where the hold
// counters are updated and the level is chosen). A stalled result holds the input register,
// so input stall rises only when both are full. Configuration registers take effect on the
// next item. The user must write them while no item is in flight; the block does not enforce it.
module load_threshold_level_governor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [13:0] load_i,
  input  logic [23:0] elapsed_us_i,
  input  logic [3:0]  current_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        request_valid_o,
  output logic [3:0]  requested_level_o
);
  import ltlg_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  load_en;

  // configuration registers
  ltlg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input register with precomputed compares
  ltlg_front u_front (
    .clk_i           (clk_i),
    .load_en_i       (load_en),
    .kind_i          (kind_i),
    .load_i          (load_i),
    .elapsed_us_i    (elapsed_us_i),
    .current_level_i (current_level_i),
    .cfg_i           (cfg),
    .item_o          (item)
  );

  // counters, decision and result register
  ltlg_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .load_en_o         (load_en),
    .item_i            (item),
    .cfg_i             (cfg),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .request_valid_o   (request_valid_o),
    .requested_level_o (requested_level_o)
  );

endmodule
